// ===== hw/rtl/mwac_pkg.sv =====
// Shared types and constants for the magnetometer window average / calibrate core.
// No dependencies; imported by mwac_lane and the top level.
package mwac_pkg;

    localparam int DATA_W      = 16;
    localparam int NUM_AXES    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int SCALE_SHIFT = 14;
    localparam int CORR_PROD_W = 2 * DATA_W + 2;

    localparam logic [DATA_W-1:0]        SCALE_ONE   = 16'd16384;
    localparam logic signed [DATA_W-1:0] RESTART_MIN = 16'sd4096;
    localparam logic signed [DATA_W-1:0] RESTART_MAX = -16'sd4096;
    localparam logic signed [DATA_W-1:0] SAT_POS     = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_NEG     = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIB    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd6;

    // per-stage advance strobes shared by all lanes
    typedef struct packed {
        logic push;     // sample request accepted, window shifts
        logic adv1;     // sum stage -> reciprocal product
        logic adv2;     // product -> average, min/max update
        logic adv3;     // average -> scale product
        logic adv4;     // scale product -> output register
        logic restart;  // item in product stage is a restart request
        logic calib;    // min/max tracking enabled
    } t_lane_ctl;

endpackage

// ===== hw/rtl/mwac_lane.sv =====
// One axis lane: sliding window with running sum, divide by window depth,
// min/max tracking and offset/scale correction. Depends on mwac_pkg.
module mwac_lane import mwac_pkg::*; #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic signed [DATA_W-1:0] i_offset,
    input  logic        [DATA_W-1:0] i_scale,
    output logic signed [DATA_W-1:0] o_avg,
    output logic signed [DATA_W-1:0] o_corr,
    output logic signed [DATA_W-1:0] o_min,
    output logic signed [DATA_W-1:0] o_max
);

    localparam int LOG_D  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = DATA_W + LOG_D;
    localparam int SHIFT  = SUM_W + LOG_D;
    localparam int PROD_W = SUM_W + SHIFT + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [SHIFT:0] RECIP = RECIP_FULL[SHIFT:0];
    localparam logic signed [CORR_PROD_W-1:0] TRUNC_BIAS =
        CORR_PROD_W'((1 << SCALE_SHIFT) - 1);

    logic signed [DATA_W-1:0]   r_win [WINDOW_DEPTH];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]           mag;
    logic [PROD_W-1:0]          r_s2_prod;
    logic                       r_s2_neg;
    logic [DATA_W:0]            quo;
    logic [DATA_W:0]            avg_ext;
    logic signed [DATA_W-1:0]   avg;
    logic signed [DATA_W:0]     n_diff;
    logic signed [DATA_W-1:0]   r_min;
    logic signed [DATA_W-1:0]   r_max;
    logic signed [DATA_W-1:0]   n_min;
    logic signed [DATA_W-1:0]   n_max;
    logic signed [DATA_W-1:0]   r_s3_avg;
    logic signed [DATA_W:0]     r_s3_diff;
    logic signed [CORR_PROD_W-1:0] r_s4_prod;
    logic signed [DATA_W-1:0]   r_s4_avg;
    logic signed [DATA_W-1:0]   r_s4_min;
    logic signed [DATA_W-1:0]   r_s4_max;
    logic signed [CORR_PROD_W-1:0] adj;
    logic signed [CORR_PROD_W-1:0] shq;
    logic [CORR_PROD_W-DATA_W:0]   upper;

    // window shift line and running sum
    assign n_sum = r_sum - SUM_W'(r_win[0]) + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctl.push) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WINDOW_DEPTH - 1] <= i_sample;
            r_sum <= n_sum;
        end
    end

    // divide by depth: magnitude times rounded-up reciprocal
    assign mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_s2_prod <= PROD_W'(mag) * PROD_W'(RECIP);
            r_s2_neg  <= r_sum[SUM_W-1];
        end
    end

    assign quo     = r_s2_prod[SHIFT +: DATA_W + 1];
    assign avg_ext = r_s2_neg ? (DATA_W + 1)'(-quo) : quo;
    assign avg     = avg_ext[DATA_W-1:0];
    assign n_diff  = {avg[DATA_W-1], avg} - {i_offset[DATA_W-1], i_offset};

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_ctl.restart) begin
            n_min = RESTART_MIN;
            n_max = RESTART_MAX;
        end else if (i_ctl.calib) begin
            if (avg < r_min) begin
                n_min = avg;
            end
            if (avg > r_max) begin
                n_max = avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_ctl.adv2) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_s3_avg  <= avg;
            r_s3_diff <= n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            r_s4_prod <= CORR_PROD_W'(r_s3_diff * $signed({1'b0, i_scale}));
            r_s4_avg  <= r_s3_avg;
            r_s4_min  <= r_min;
            r_s4_max  <= r_max;
        end
    end

    // truncate toward zero, then saturate
    assign adj   = r_s4_prod + (r_s4_prod[CORR_PROD_W-1] ? TRUNC_BIAS : '0);
    assign shq   = adj >>> SCALE_SHIFT;
    assign upper = shq[CORR_PROD_W-1:DATA_W-1];

    always_comb begin
        if (&upper || ~|upper) begin
            o_corr = shq[DATA_W-1:0];
        end else if (shq[CORR_PROD_W-1]) begin
            o_corr = SAT_NEG;
        end else begin
            o_corr = SAT_POS;
        end
    end

    assign o_avg = r_s4_avg;
    assign o_min = r_s4_min;
    assign o_max = r_s4_max;

endmodule

// ===== hw/rtl/magnetometer_window_average_calibrate_core.sv =====
// Throughput: one request per cycle unless m_axis_tready back-pressure stalls the pipeline;
// each axis lane has a four-stage pipeline with one reciprocal multiplier and one scale
// multiplier, and the output register merges the lanes.
// Reset (synchronous, i_rst_n low): windows, sums, min/max cleared, scales set to 1.0,
// offsets and calibration enable cleared, pipeline emptied. Depends on mwac_pkg, mwac_lane.
module magnetometer_window_average_calibrate_core import mwac_pkg::*; #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [47:0]               s_axis_tdata,  // raw_x, raw_y, raw_z
    input  logic                      s_axis_tuser,  // command
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [191:0]              m_axis_tdata,  // avg_x/y/z, corr_x/y/z, min_x/y/z, max_x/y/z
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [DATA_W-1:0]         i_cfg_data
);

    logic                     r_calib;
    logic signed [DATA_W-1:0] r_offset [NUM_AXES];
    logic [DATA_W-1:0]        r_scale  [NUM_AXES];

    logic signed [DATA_W-1:0] board [NUM_AXES];
    logic signed [DATA_W-1:0] l_avg [NUM_AXES];
    logic signed [DATA_W-1:0] l_corr[NUM_AXES];
    logic signed [DATA_W-1:0] l_min [NUM_AXES];
    logic signed [DATA_W-1:0] l_max [NUM_AXES];

    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic r_cmd1, r_cmd2;
    logic out_free, s4_free, s3_free, s2_free, s1_free;
    logic accept;
    logic [191:0] r_o_data;
    logic [191:0] n_o_data;
    t_lane_ctl    ctl;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_offset[a] <= '0;
                r_scale[a]  <= SCALE_ONE;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CALIB:    r_calib     <= i_cfg_data[0];
                CFG_OFFSET_X: r_offset[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                CFG_SCALE_X:  r_scale[0]  <= i_cfg_data;
                CFG_SCALE_Y:  r_scale[1]  <= i_cfg_data;
                CFG_SCALE_Z:  r_scale[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sensor to board frame
    assign board[0] = s_axis_tdata[31:16];
    assign board[1] = -$signed(s_axis_tdata[15:0]);
    assign board[2] = s_axis_tdata[47:32];

    // pipeline flow control
    assign out_free = !r_o_valid || m_axis_tready;
    assign s4_free  = !r_v4 || out_free;
    assign s3_free  = !r_v3 || s4_free;
    assign s2_free  = !r_v2 || s3_free;
    assign s1_free  = !r_v1 || s2_free;
    assign accept   = s_axis_tvalid && s1_free;
    assign s_axis_tready = s1_free;

    assign ctl.push    = accept && !s_axis_tuser;
    assign ctl.adv1    = r_v1 && s2_free;
    assign ctl.adv2    = r_v2 && s3_free;
    assign ctl.adv3    = r_v3 && s4_free;
    assign ctl.adv4    = r_v4 && out_free;
    assign ctl.restart = r_cmd2;
    assign ctl.calib   = r_calib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s1_free)  r_v1      <= accept;
            if (s2_free)  r_v2      <= r_v1;
            if (s3_free)  r_v3      <= r_v2;
            if (s4_free)  r_v4      <= r_v3;
            if (out_free) r_o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)   r_cmd1 <= s_axis_tuser;
        if (ctl.adv1) r_cmd2 <= r_cmd1;
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        mwac_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_sample (board[a]),
            .i_offset (r_offset[a]),
            .i_scale  (r_scale[a]),
            .o_avg    (l_avg[a]),
            .o_corr   (l_corr[a]),
            .o_min    (l_min[a]),
            .o_max    (l_max[a])
        );
    end

    // merge lanes into the output register
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_o_data[a * DATA_W +: DATA_W]                  = l_avg[a];
            n_o_data[(NUM_AXES + a) * DATA_W +: DATA_W]     = l_corr[a];
            n_o_data[(2 * NUM_AXES + a) * DATA_W +: DATA_W] = l_min[a];
            n_o_data[(3 * NUM_AXES + a) * DATA_W +: DATA_W] = l_max[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv4) begin
            r_o_data <= n_o_data;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted request did not enter the pipeline");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !m_axis_tready && r_v1 && r_v2 && r_v3 && r_v4) |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    a_s4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !out_free) |=> r_v4)
        else $error("stalled item dropped from last stage");

endmodule

// ===== verif/tb_magnetometer_window_average_calibrate_core.sv =====
// Self-checking testbench for magnetometer_window_average_calibrate_core: queue-fed stream
// driver, result monitor with field-by-field compare against an in-bench window/min-max model.
// Depends on mwac_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_magnetometer_window_average_calibrate_core import mwac_pkg::*;;

    localparam int WINDOW_DEPTH = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_REQS   = 96;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } t_mag_cmd;

    typedef struct packed {
        t_mag_cmd                 command;
        logic signed [DATA_W-1:0] raw_x;
        logic signed [DATA_W-1:0] raw_y;
        logic signed [DATA_W-1:0] raw_z;
    } t_mag_req;

    // avg_x in the lowest bits, same layout as m_axis_tdata
    typedef struct packed {
        logic signed [DATA_W-1:0] max_z, max_y, max_x;
        logic signed [DATA_W-1:0] min_z, min_y, min_x;
        logic signed [DATA_W-1:0] corr_z, corr_y, corr_x;
        logic signed [DATA_W-1:0] avg_z, avg_y, avg_x;
    } t_mag_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;  // raw_x, raw_y, raw_z
    logic                 s_axis_tuser  = 1'b0;  // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [191:0]         m_axis_tdata;  // avg_x/y/z, corr_x/y/z, min_x/y/z, max_x/y/z
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [DATA_W-1:0]    i_cfg_data    = '0;

    magnetometer_window_average_calibrate_core #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // model state and register copies
    logic signed [DATA_W-1:0] win_hist [NUM_AXES][WINDOW_DEPTH] = '{default: '0};
    logic signed [DATA_W-1:0] trk_min  [NUM_AXES] = '{default: '0};
    logic signed [DATA_W-1:0] trk_max  [NUM_AXES] = '{default: '0};
    logic                     m_calib = 1'b0;
    logic signed [DATA_W-1:0] m_offset [NUM_AXES] = '{default: '0};
    logic [DATA_W-1:0]        m_scale  [NUM_AXES] = '{default: SCALE_ONE};

    t_mag_req    pending_q [$];
    t_mag_result exp_q [$];
    t_mag_req    cur_req;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_fail     = 0;

    int src_idle_pct = 25;
    int dst_idle_pct = 25;
    int src_gap      = 0;
    int dst_gap      = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    string fld_name [12] = '{"avg_x", "avg_y", "avg_z", "corr_x", "corr_y", "corr_z",
                             "min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

    function automatic t_mag_result mag_predict(t_mag_req r);
        logic signed [DATA_W-1:0] board [NUM_AXES];
        logic signed [DATA_W-1:0] avg   [NUM_AXES];
        logic signed [DATA_W-1:0] corr  [NUM_AXES];
        int                       sum;
        int                       a;
        int                       i;
        longint                   prod;
        t_mag_result              res;
        board[0] = r.raw_y;
        board[1] = -r.raw_x;  // wraps at 16 bits
        board[2] = r.raw_z;
        for (a = 0; a < NUM_AXES; a++) begin
            if (r.command == CMD_SAMPLE) begin
                for (i = 1; i < WINDOW_DEPTH; i++)
                    win_hist[a][i-1] = win_hist[a][i];
                win_hist[a][WINDOW_DEPTH-1] = board[a];
            end
            sum = 0;
            for (i = 0; i < WINDOW_DEPTH; i++)
                sum += win_hist[a][i];
            avg[a] = DATA_W'(sum / WINDOW_DEPTH);
            if (r.command == CMD_RESTART) begin
                trk_min[a] = RESTART_MIN;
                trk_max[a] = RESTART_MAX;
            end else if (m_calib) begin
                if (avg[a] < trk_min[a])
                    trk_min[a] = avg[a];
                if (avg[a] > trk_max[a])
                    trk_max[a] = avg[a];
            end
            prod = ((longint'(avg[a]) - longint'(m_offset[a])) * longint'(m_scale[a]))
                   / longint'(SCALE_ONE);
            if (prod > 32767)
                corr[a] = SAT_POS;
            else if (prod < -32768)
                corr[a] = SAT_NEG;
            else
                corr[a] = prod[DATA_W-1:0];
        end
        res.avg_x  = avg[0];     res.avg_y  = avg[1];     res.avg_z  = avg[2];
        res.corr_x = corr[0];    res.corr_y = corr[1];    res.corr_z = corr[2];
        res.min_x  = trk_min[0]; res.min_y  = trk_min[1]; res.min_z  = trk_min[2];
        res.max_x  = trk_max[0]; res.max_y  = trk_max[1]; res.max_z  = trk_max[2];
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] rand_axis(logic [DATA_W-1:0] base);
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? SAT_POS : SAT_NEG;
            1, 2:    return DATA_W'($urandom);
            default: return base + DATA_W'($urandom_range(1023)) - DATA_W'(512);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] cfg_value();
        case ($urandom_range(6))
            0:       return SAT_NEG;
            1:       return SAT_POS;
            2:       return '0;
            3:       return '1;
            4:       return SCALE_ONE;
            5:       return SCALE_ONE + DATA_W'($urandom_range(4095)) - DATA_W'(2048);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic push_req(t_mag_cmd cmd, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z);
        t_mag_req r;
        r.command = cmd;
        r.raw_x   = x;
        r.raw_y   = y;
        r.raw_z   = z;
        pending_q.push_back(r);
        n_queued++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CALIB:                              m_calib = val[0];
            CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z: m_offset[2'(idx - CFG_OFFSET_X)] = val;
            CFG_SCALE_X, CFG_SCALE_Y, CFG_SCALE_Z:    m_scale[2'(idx - CFG_SCALE_X)] = val;
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic calib, logic [DATA_W-1:0] ox, logic [DATA_W-1:0] oy,
                           logic [DATA_W-1:0] oz, logic [DATA_W-1:0] sx,
                           logic [DATA_W-1:0] sy, logic [DATA_W-1:0] sz);
        logic [DATA_W-1:0] cal_word;
        cal_word    = DATA_W'($urandom);
        cal_word[0] = calib;
        cfg_write(CFG_CALIB, cal_word);
        cfg_write(CFG_OFFSET_X, ox);
        cfg_write(CFG_OFFSET_Y, oy);
        cfg_write(CFG_OFFSET_Z, oz);
        cfg_write(CFG_SCALE_X, sx);
        cfg_write(CFG_SCALE_Y, sy);
        cfg_write(CFG_SCALE_Z, sz);
        cfg_write(CFG_UNUSED, DATA_W'($urandom));  // must be ignored
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (n_accepted == n_queued && n_checked == n_queued);
        @(posedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                exp_q.push_back(mag_predict(cur_req));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_req = pending_q.pop_front();
                    s_axis_tdata  <= {cur_req.raw_z, cur_req.raw_y, cur_req.raw_x};
                    s_axis_tuser  <= cur_req.command;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(99) < src_idle_pct)
                        src_gap = $urandom_range(16, 1);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done = 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_mag_result exp_res;
        logic [191:0] ev;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_checked++;
                if (exp_q.size() == 0) begin
                    $error("result with no request pending: %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    exp_res = exp_q.pop_front();
                    ev = exp_res;
                    for (int f = 0; f < 12; f++) begin
                        if (ev[16*f +: 16] !== m_axis_tdata[16*f +: 16]) begin
                            $error("%s expected %0d actual %0d", fld_name[f],
                                   $signed(ev[16*f +: 16]), $signed(m_axis_tdata[16*f +: 16]));
                            n_fail++;
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (dst_gap > 0) begin
                dst_gap--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < dst_idle_pct) begin
                dst_gap = $urandom_range(16, 1) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] base_x, base_y, base_z;
        int ph;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: extremes, negation of the most negative x, restart
        push_req(CMD_SAMPLE, SAT_NEG, SAT_NEG, SAT_NEG);
        push_req(CMD_SAMPLE, SAT_POS, SAT_POS, SAT_POS);
        push_req(CMD_RESTART, DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        push_req(CMD_SAMPLE, '0, '0, '0);
        drain();

        // tracking on, full gain: saturation as the window fills
        cfg_all(1'b1, '0, '0, '0, '1, '1, '1);
        repeat (6) push_req(CMD_SAMPLE, SAT_NEG, SAT_POS, SAT_NEG);
        push_req(CMD_RESTART, '1, '1, '1);
        repeat (2) push_req(CMD_SAMPLE, SAT_NEG, SAT_POS, SAT_NEG);
        drain();

        // extreme offsets: clamp high on x, clamp low on y, zero gain on z
        cfg_all(1'b1, SAT_NEG, SAT_POS, SAT_POS, '1, '1, '0);
        repeat (5) push_req(CMD_SAMPLE, SAT_POS, SAT_POS, SAT_NEG);
        push_req(CMD_SAMPLE, '1, '1, '1);
        drain();

        // tracking off: min/max frozen except where the restart request resets them
        cfg_all(1'b0, '0, '1, SAT_NEG, SCALE_ONE, '0, SCALE_ONE);
        push_req(CMD_SAMPLE, 16'h1234, 16'hEDCB, 16'h0F0F);
        push_req(CMD_SAMPLE, 16'hAAAA, 16'h5555, 16'hFFFF);
        push_req(CMD_RESTART, '0, '0, '0);
        push_req(CMD_SAMPLE, 16'h5555, 16'hAAAA, 16'h0001);
        drain();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                1:       begin src_idle_pct = 0;  dst_idle_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_idle_pct = 0;  end
                3:       begin src_idle_pct = 60; dst_idle_pct = 10; end
                4:       begin src_idle_pct = 10; dst_idle_pct = 60; end
                5:       begin src_idle_pct = 0;  dst_idle_pct = 0;  end
                default: begin src_idle_pct = 30; dst_idle_pct = 30; end
            endcase
            cfg_all((ph % 3) != 2, cfg_value(), cfg_value(), cfg_value(),
                    cfg_value(), cfg_value(), cfg_value());
            base_x = DATA_W'($urandom);
            base_y = DATA_W'($urandom);
            base_z = DATA_W'($urandom);
            if (ph == 2)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(24) == 0)
                    push_req(CMD_RESTART, DATA_W'($urandom), DATA_W'($urandom),
                             DATA_W'($urandom));
                else
                    push_req(CMD_SAMPLE, rand_axis(base_x), rand_axis(base_y),
                             rand_axis(base_z));
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && exp_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
